// ===== src/assert_macros.svh =====
// Assertion macros used by the top level RTL file of the report tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_HOLDS(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition is never true at a rising clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_HOLDS(name, clk, rst, prop, msg)
`define ASSERT_NEVER(name, clk, rst, cond, msg)

`endif

`endif

// ===== src/hkrt_pkg.sv =====
// Package with the types and constants of the keyboard report tracker.
package hkrt_pkg;

   // Width of a usage code and number of usage codes.
   localparam int KEY_W     = 8;
   localparam int KEY_CODES = 256;

   // Number of slot fields in a report.
   localparam int OUT_SLOTS = 6;

   // Special usage codes.
   localparam logic [KEY_W-1:0] CODE_NONE     = 8'h00;
   localparam logic [KEY_W-1:0] CODE_ROLLOVER = 8'h01;

   // Modifier codes occupy 0xE0 to 0xE7; the upper five bits identify them.
   localparam logic [4:0] MOD_PREFIX = 5'b11100;

   // Event kinds carried on the action field.
   localparam logic ACT_PRESS   = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK
   } state_type;

endpackage

// ===== src/hid_keyboard_report_tracker_unit.sv =====
// Top level of the keyboard report tracker: down map, report slots and output stage.
//
//   channel   direction  signals
//   req       in         req_valid, req_ready, req_action, req_key
//   rsp       out        rsp_valid, rsp_ready, rsp_modifiers, rsp_slot_zero..rsp_slot_five
//
// After reset the down map RAM is cleared one entry per cycle, with req_ready low meanwhile.
// Each request first reads its down map entry in ST_IDLE, then updates and writes it back in ST_LOOK.
// A request that changes the map loads the output register; the next request may enter
// while that report waits, but the update cycle holds until the output register is free.
// Requests with usage code zero or a repeated press or release give no report.
module hid_keyboard_report_tracker_unit
   import hkrt_pkg::*;
#(
   parameter int SLOT_COUNT = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_action,
   input  logic [KEY_W-1:0] req_key,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_modifiers,
   output logic [KEY_W-1:0] rsp_slot_zero,
   output logic [KEY_W-1:0] rsp_slot_one,
   output logic [KEY_W-1:0] rsp_slot_two,
   output logic [KEY_W-1:0] rsp_slot_three,
   output logic [KEY_W-1:0] rsp_slot_four,
   output logic [KEY_W-1:0] rsp_slot_five
);

`include "assert_macros.svh"

   localparam logic [7:0] SLOTS_CNT  = 8'(SLOT_COUNT);
   localparam logic [7:0] SLOTS_OVER = 8'(SLOT_COUNT + 1);

   state_type state_ff, state_in;

   logic [KEY_W-1:0] clear_addr_ff, clear_addr_in;
   logic             action_ff;
   logic [KEY_W-1:0] key_ff;

   logic [KEY_W-1:0] slot_ff  [SLOT_COUNT];
   logic [KEY_W-1:0] slot_in  [SLOT_COUNT];
   logic [KEY_W-1:0] saved_ff [SLOT_COUNT];
   logic [KEY_W-1:0] saved_in [SLOT_COUNT];
   logic [7:0]       held_ff, held_in;
   logic [7:0]       mods_ff, mods_in;

   logic             rsp_valid_ff;
   logic [7:0]       rsp_mods_ff;
   logic [KEY_W-1:0] rsp_slot_ff [OUT_SLOTS];
   logic [KEY_W-1:0] rsp_view    [OUT_SLOTS];

   logic             ram_we;
   logic [KEY_W-1:0] ram_waddr;
   logic             ram_wdata;
   logic [KEY_W-1:0] ram_raddr;
   logic             key_down;
   logic             accept;
   logic             changes;
   logic             out_free;
   logic             commit;
   logic             is_mod;

   // Down map storage.
   hkrt_ram #(
      .WIDTH (1),
      .DEPTH (KEY_CODES)
   ) u_down_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (key_down)
   );

   assign accept   = req_valid && req_ready;
   assign changes  = (action_ff == ACT_RELEASE) ? key_down : !key_down;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign commit   = (state_ff == ST_LOOK) && changes && out_free;
   assign is_mod   = (key_ff[KEY_W-1:3] == MOD_PREFIX);

   // Sequencer: clearing pass, request intake and read-modify-write of the down map.
   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      req_ready     = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = key_ff;
      ram_wdata     = 1'b0;
      ram_raddr     = key_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we        = 1'b1;
            ram_waddr     = clear_addr_ff;
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == KEY_W'(KEY_CODES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            ram_raddr = req_key;
            if (req_valid && (req_key != CODE_NONE)) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            ram_wdata = (action_ff == ACT_PRESS);
            if (!changes) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               ram_we   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Next slots, saved slots, held count and modifiers for the request in the update cycle.
   always_comb begin
      logic done;
      logic passed;
      logic [KEY_W-1:0] nxt;
      slot_in  = slot_ff;
      saved_in = saved_ff;
      held_in  = held_ff;
      mods_in  = mods_ff;
      done     = 1'b0;
      passed   = 1'b0;
      nxt      = CODE_NONE;
      if (is_mod) begin
         if (action_ff == ACT_PRESS) begin
            mods_in = mods_ff | (8'd1 << key_ff[2:0]);
         end else begin
            mods_in = mods_ff & ~(8'd1 << key_ff[2:0]);
         end
      end else if (action_ff == ACT_PRESS) begin
         if (held_ff < SLOTS_CNT) begin
            // Place the key in the first free slot.
            for (int j = 0; j < SLOT_COUNT; j++) begin
               if (!done && (slot_ff[j] == CODE_NONE)) begin
                  slot_in[j] = key_ff;
                  done       = 1'b1;
               end
            end
            if (done) begin
               saved_in = slot_in;
               held_in  = held_ff + 8'd1;
            end
         end else begin
            // Rollover: every slot shows the error code.
            for (int j = 0; j < SLOT_COUNT; j++) begin
               slot_in[j] = CODE_ROLLOVER;
            end
            if (held_ff != 8'hFF) begin
               held_in = held_ff + 8'd1;
            end
         end
      end else begin
         if (held_ff == SLOTS_OVER) begin
            held_in = held_ff - 8'd1;
            slot_in = saved_ff;
         end else if (held_ff > SLOTS_OVER) begin
            held_in = held_ff - 8'd1;
         end else begin
            // Remove the first matching slot and shift the later ones down.
            for (int j = 0; j < SLOT_COUNT; j++) begin
               if (j + 1 < SLOT_COUNT) begin
                  nxt = slot_ff[(j + 1) % SLOT_COUNT];
               end else begin
                  nxt = CODE_NONE;
               end
               if (slot_ff[j] == key_ff) begin
                  passed = 1'b1;
               end
               if (passed) begin
                  slot_in[j] = nxt;
               end
            end
            if (passed && (held_ff != 8'd0)) begin
               held_in = held_ff - 8'd1;
            end
         end
      end
   end

   // Report view: fields without a slot behind them read zero.
   for (genvar g = 0; g < OUT_SLOTS; g++) begin : g_view
      if (g < SLOT_COUNT) begin : g_slot
         assign rsp_view[g] = slot_in[g];
      end else begin : g_none
         assign rsp_view[g] = CODE_NONE;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         held_ff       <= 8'd0;
         mods_ff       <= 8'd0;
         for (int j = 0; j < SLOT_COUNT; j++) begin
            slot_ff[j]  <= CODE_NONE;
            saved_ff[j] <= CODE_NONE;
         end
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
            held_ff      <= held_in;
            mods_ff      <= mods_in;
            slot_ff      <= slot_in;
            saved_ff     <= saved_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request capture and report payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         key_ff    <= req_key;
      end
      if (commit) begin
         rsp_mods_ff <= mods_in;
         rsp_slot_ff <= rsp_view;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_modifiers  = rsp_mods_ff;
   assign rsp_slot_zero  = rsp_slot_ff[0];
   assign rsp_slot_one   = rsp_slot_ff[1];
   assign rsp_slot_two   = rsp_slot_ff[2];
   assign rsp_slot_three = rsp_slot_ff[3];
   assign rsp_slot_four  = rsp_slot_ff[4];
   assign rsp_slot_five  = rsp_slot_ff[5];

   // Checks on the sequencer and the slot state.
   `ASSERT_NEVER(a_no_report_in_clear, clock, reset, rsp_valid_ff && (state_ff == ST_CLEAR), "report pending during clearing pass")
   `ASSERT_HOLDS(a_report_from_update, clock, reset, (!$past(reset) && $rose(rsp_valid_ff)) |-> ($past(state_ff) == ST_LOOK), "report raised outside an update cycle")
   `ASSERT_HOLDS(a_rollover_shown, clock, reset, (held_ff > SLOTS_CNT) |-> (slot_ff[0] == CODE_ROLLOVER), "held count above slots without rollover code")
   `ASSERT_HOLDS(a_held_step, clock, reset, !$past(reset) |-> ((held_ff == $past(held_ff)) || (held_ff == $past(held_ff) + 8'd1) || (held_ff == $past(held_ff) - 8'd1)), "held count moved by more than one")

endmodule

// ===== src/hkrt_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module hkrt_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== dv/hid_keyboard_report_tracker_unit_tb.sv =====
// Self-checking testbench for the keyboard report tracker with a built-in report predictor.
`timescale 1ns / 100ps

module hid_keyboard_report_tracker_unit_tb;
   import hkrt_pkg::*;

   localparam int SLOTS          = 6;
   localparam int ITEM_TARGET    = 1150;
   localparam int HOLD_CYCLES    = 120;
   localparam int DRAIN_CYCLES   = 20;
   localparam int IDLE_LIMIT     = 2000;
   localparam int SHOWN_ERRORS   = 10;

   // One report as it appears on the response channel.
   typedef struct packed {
      logic [7:0]                      modifiers;
      logic [OUT_SLOTS-1:0][KEY_W-1:0] slot;
   } report_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic             req_action;
   logic [KEY_W-1:0] req_key;
   logic             rsp_valid;
   logic             rsp_ready;
   logic [7:0]       rsp_modifiers;
   logic [KEY_W-1:0] rsp_slot_zero;
   logic [KEY_W-1:0] rsp_slot_one;
   logic [KEY_W-1:0] rsp_slot_two;
   logic [KEY_W-1:0] rsp_slot_three;
   logic [KEY_W-1:0] rsp_slot_four;
   logic [KEY_W-1:0] rsp_slot_five;

   // Predicted keyboard state.
   bit               key_is_down [KEY_CODES];
   logic [KEY_W-1:0] slot_codes  [SLOTS];
   logic [KEY_W-1:0] saved_codes [SLOTS];
   logic [7:0]       held_keys;
   logic [7:0]       mod_bits;

   report_type       pending_reports[$];
   int               items_sent;
   int               report_errors;
   int               idle_cycles;
   bit               hold_rsp;
   bit               steady;
   logic [KEY_W-1:0] key_pool [12];

   hid_keyboard_report_tracker_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_modifiers  (rsp_modifiers),
      .rsp_slot_zero  (rsp_slot_zero),
      .rsp_slot_one   (rsp_slot_one),
      .rsp_slot_two   (rsp_slot_two),
      .rsp_slot_three (rsp_slot_three),
      .rsp_slot_four  (rsp_slot_four),
      .rsp_slot_five  (rsp_slot_five)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Applies one key event to the predicted state; returns 1 when it yields a report.
   function automatic bit track_key_event(input logic act, input logic [KEY_W-1:0] key,
                                          output report_type rep);
      int  hit;
      bit  placed;
      bit  is_mod;
      rep    = '0;
      hit    = -1;
      placed = 1'b0;
      is_mod = (key[7:3] == MOD_PREFIX);
      if (key == CODE_NONE) return 1'b0;
      if (act == ACT_RELEASE) begin
         if (!key_is_down[key]) return 1'b0;
         key_is_down[key] = 1'b0;
         if (is_mod) begin
            mod_bits[key[2:0]] = 1'b0;
         end else if (held_keys == SLOTS + 1) begin
            held_keys  = held_keys - 1;
            slot_codes = saved_codes;
         end else if (held_keys > SLOTS + 1) begin
            held_keys = held_keys - 1;
         end else begin
            // Drop the first matching slot and close the gap behind it.
            for (int i = 0; i < SLOTS; i++) begin
               if (hit < 0 && slot_codes[i] == key) hit = i;
            end
            if (hit >= 0) begin
               if (held_keys > 0) held_keys = held_keys - 1;
               for (int j = hit; j + 1 < SLOTS; j++) slot_codes[j] = slot_codes[j + 1];
               slot_codes[SLOTS - 1] = CODE_NONE;
            end
         end
      end else begin
         if (key_is_down[key]) return 1'b0;
         key_is_down[key] = 1'b1;
         if (is_mod) begin
            mod_bits[key[2:0]] = 1'b1;
         end else if (held_keys < SLOTS) begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!placed && slot_codes[i] == CODE_NONE) begin
                  slot_codes[i] = key;
                  saved_codes   = slot_codes;
                  held_keys     = held_keys + 1;
                  placed        = 1'b1;
               end
            end
         end else begin
            // Too many keys: every slot reports the rollover error.
            for (int i = 0; i < SLOTS; i++) slot_codes[i] = CODE_ROLLOVER;
            if (held_keys < 8'd255) held_keys = held_keys + 1;
         end
      end
      rep.modifiers = mod_bits;
      for (int i = 0; i < OUT_SLOTS; i++) rep.slot[i] = (i < SLOTS) ? slot_codes[i] : '0;
      return 1'b1;
   endfunction

   // Offers one request after a random gap (none in steady mode) and records its expected report, if any.
   task automatic send_request(input logic act, input logic [KEY_W-1:0] key);
      int         gap;
      report_type rep;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_key    <= key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (track_key_event(act, key, rep)) begin
         pending_reports.push_back(rep);
      end
   endtask

   // Toggles keys from a fresh pool, mixes in noise, then lets every key go.
   task automatic typing_session(input int items, input int noise_pct);
      logic [KEY_W-1:0] key;
      for (int i = 0; i < $size(key_pool); i++) begin
         if ($urandom_range(0, 3) == 0) key_pool[i] = {MOD_PREFIX, 3'($urandom_range(0, 7))};
         else key_pool[i] = KEY_W'($urandom_range(1, 255));
      end
      for (int n = 0; n < items; n++) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            send_request(1'($urandom_range(0, 1)), KEY_W'($urandom_range(0, 255)));
         end else begin
            key = key_pool[$urandom_range(0, $size(key_pool) - 1)];
            send_request(key_is_down[key] ? ACT_RELEASE : ACT_PRESS, key);
         end
      end
      for (int k = 1; k < KEY_CODES; k++) begin
         if (key_is_down[k]) send_request(ACT_RELEASE, KEY_W'(k));
      end
   endtask

   // Usage code zero and a release of a key that is up are both ignored.
   task automatic test_ignored_codes();
      send_request(ACT_PRESS, CODE_NONE);
      send_request(ACT_RELEASE, CODE_NONE);
      send_request(ACT_RELEASE, 8'h04);
   endtask

   // The lowest and highest modifier codes and one in between.
   task automatic test_modifier_keys();
      send_request(ACT_PRESS, 8'hE0);
      send_request(ACT_PRESS, 8'hE7);
      send_request(ACT_PRESS, 8'hE3);
      send_request(ACT_RELEASE, 8'hE0);
      send_request(ACT_RELEASE, 8'hE7);
      send_request(ACT_RELEASE, 8'hE3);
   endtask

   // Fill all slots, go into rollover twice over, then come back out of it.
   task automatic test_rollover_recovery();
      send_request(ACT_PRESS, CODE_ROLLOVER);
      send_request(ACT_PRESS, 8'h05);
      send_request(ACT_PRESS, 8'h06);
      send_request(ACT_PRESS, 8'h07);
      send_request(ACT_PRESS, 8'h08);
      send_request(ACT_PRESS, 8'hFF);
      send_request(ACT_PRESS, 8'h09);
      send_request(ACT_PRESS, 8'h0A);
      // A repeated press is ignored even in rollover.
      send_request(ACT_PRESS, 8'h09);
      send_request(ACT_RELEASE, 8'h0A);
      send_request(ACT_RELEASE, CODE_ROLLOVER);
      // This key never made it into a slot.
      send_request(ACT_RELEASE, 8'h09);
      send_request(ACT_RELEASE, 8'h05);
   endtask

   // The receiver holds off for a long stretch while requests keep coming.
   task automatic test_output_backpressure();
      hold_rsp = 1'b1;
      typing_session(16, 0);
   endtask

   // Requests and responses with no idle cycles at all.
   task automatic test_back_to_back();
      steady = 1'b1;
      typing_session(100, 10);
      steady = 1'b0;
   endtask

   // Random typing sessions until about the planned number of requests has been sent.
   task automatic test_random_typing();
      while (items_sent < ITEM_TARGET) typing_session(60, 15);
   endtask

   // Stimulus sequence and final verdict.
   initial begin
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_action <= ACT_PRESS;
      req_key    <= CODE_NONE;
      held_keys   = '0;
      mod_bits    = '0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_codes[i]  = CODE_NONE;
         saved_codes[i] = CODE_NONE;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_ignored_codes();
      test_modifier_keys();
      test_rollover_recovery();
      test_output_backpressure();
      test_back_to_back();
      test_random_typing();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (report_errors == 0 && pending_reports.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Response side: random stalls, a steady mode and one long hold-off on request.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (steady) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // Compare each accepted report with the oldest expected one.
   always @(posedge clock) begin
      report_type seen;
      report_type want;
      bit         bad;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.modifiers = rsp_modifiers;
         seen.slot[0]   = rsp_slot_zero;
         seen.slot[1]   = rsp_slot_one;
         seen.slot[2]   = rsp_slot_two;
         seen.slot[3]   = rsp_slot_three;
         seen.slot[4]   = rsp_slot_four;
         seen.slot[5]   = rsp_slot_five;
         if (pending_reports.size() == 0) begin
            report_errors++;
            if (report_errors <= SHOWN_ERRORS)
               $display("unexpected report: mods %h slots %h", seen.modifiers, seen.slot);
         end else begin
            want = pending_reports.pop_front();
            bad  = (seen.modifiers !== want.modifiers);
            for (int i = 0; i < OUT_SLOTS; i++) bad |= (seen.slot[i] !== want.slot[i]);
            if (bad) begin
               report_errors++;
               if (report_errors <= SHOWN_ERRORS)
                  $display("report mismatch: expected mods %h slots %h, got mods %h slots %h",
                           want.modifiers, want.slot, seen.modifiers, seen.slot);
            end
         end
      end
   end

   // Ends the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
